@@ rtl/ewz_pkg.sv @@
// Shared types and constants for the dual EMA and Welford z-score feature block.
// Used by ewz_serial, ewz_state and ema_welford_zscore_features_unit.
package ewz_pkg;

  localparam int NumSymbolsDef = 4;
  localparam int FracBits      = 16;

  localparam logic [15:0] AlphaFastReset = 16'd11916;
  localparam logic [15:0] AlphaSlowReset = 16'd2570;
  localparam logic [30:0] InitPriceReset = 31'd9830400;

  // Configuration register indexes.
  localparam logic [1:0] RegAlphaFast = 2'd0;
  localparam logic [1:0] RegAlphaSlow = 2'd1;
  localparam logic [1:0] RegInitPrice = 2'd2;

  // Step counts of the serial unit for each operation.
  localparam logic [6:0] StepsEma  = 7'd16;
  localparam logic [6:0] StepsWide = 7'd49;
  localparam logic [6:0] StepsVar  = 7'd64;
  localparam logic [6:0] StepsSqrt = 7'd32;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } ser_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FAST_GO,
    ST_FAST_WAIT,
    ST_SLOW_GO,
    ST_SLOW_WAIT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_DELTA2,
    ST_DEV_GO,
    ST_DEV_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_Z_GO,
    ST_Z_WAIT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic        start;
    ser_op_t     op;
    logic [63:0] a;      // multiplicand or divisor
    logic [63:0] b;      // multiplier, left-aligned dividend or radicand
    logic [6:0]  steps;
  } ser_cmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] acc;    // high product or remainder
    logic [63:0] low;    // low product bits or quotient
    logic [31:0] root;
  } ser_res_t;

  typedef struct packed {
    logic signed [31:0] fast;
    logic signed [31:0] slow;
    logic signed [47:0] mean;
    logic        [63:0] sum;
    logic        [31:0] cnt;
  } sym_state_t;

endpackage

@@ rtl/ewz_serial.sv @@
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit of result per cycle. Depends on ewz_pkg.
module ewz_serial import ewz_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ser_cmd_t cmd,
  output ser_res_t res
);

  ser_op_t     op;
  logic [63:0] a_r;
  logic [63:0] acc;
  logic [63:0] low;
  logic [31:0] root;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;

  logic [63:0] acc_next;
  logic [63:0] low_next;
  logic [31:0] root_next;
  logic [64:0] mul_sum;
  logic [32:0] div_t;
  logic [32:0] div_diff;
  logic [35:0] sq_t;
  logic [35:0] sq_trial;
  logic [35:0] sq_diff;

  always_comb begin
    mul_sum   = {1'b0, acc} + (low[0] ? {1'b0, a_r} : 65'd0);
    div_t     = {acc[31:0], low[63]};
    div_diff  = div_t - {1'b0, a_r[31:0]};
    sq_t      = {acc[33:0], low[63:62]};
    sq_trial  = {2'b00, root, 2'b01};
    sq_diff   = sq_t - sq_trial;
    acc_next  = acc;
    low_next  = low;
    root_next = root;
    case (op)
      OP_MUL: begin
        acc_next = mul_sum[64:1];
        low_next = {mul_sum[0], low[63:1]};
      end
      OP_DIV: begin
        if (div_t >= {1'b0, a_r[31:0]}) begin
          acc_next = {32'd0, div_diff[31:0]};
          low_next = {low[62:0], 1'b1};
        end else begin
          acc_next = {32'd0, div_t[31:0]};
          low_next = {low[62:0], 1'b0};
        end
      end
      OP_SQRT: begin
        low_next = {low[61:0], 2'b00};
        if (sq_t >= sq_trial) begin
          acc_next  = {28'd0, sq_diff};
          root_next = {root[30:0], 1'b1};
        end else begin
          acc_next  = {28'd0, sq_t};
          root_next = {root[30:0], 1'b0};
        end
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
      op   <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
        op   <= cmd.op;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r  <= cmd.a;
      low  <= cmd.b;
      acc  <= 64'd0;
      root <= 32'd0;
    end else if (busy) begin
      acc  <= acc_next;
      low  <= low_next;
      root <= root_next;
    end
  end

  assign res.done = done;
  assign res.acc  = acc;
  assign res.low  = low;
  assign res.root = root;

endmodule

@@ rtl/ewz_state.sv @@
// Per-symbol state memory with valid bits; an entry that is not valid reads
// as the reload value built from the starting price. Depends on ewz_pkg.
module ewz_state import ewz_pkg::*; #(
  parameter int NUM_SYMBOLS = NumSymbolsDef,
  parameter int IDX_W       = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  sym_state_t       wr_data,
  input  logic [30:0]      start_level,
  output sym_state_t       rd_data
);

  sym_state_t             mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] valid;
  sym_state_t             rd_q;
  logic                   rd_valid;
  sym_state_t             reload;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_idx];
      end
    end
  end

  always_comb begin
    reload.fast = {1'b0, start_level};
    reload.slow = {1'b0, start_level};
    reload.mean = {1'b0, start_level, 16'd0};
    reload.sum  = 64'd0;
    reload.cnt  = 32'd1;
    rd_data     = rd_valid ? rd_q : reload;
  end

endmodule

@@ rtl/ema_welford_zscore_features_unit.sv @@
// Dual EMA and Welford z-score feature unit, one tick at a time.
// Each tick passes through up to seven bit-serial operations of 16 to 64 steps,
// the z-score division being skipped when the spread is zero; most of the time
// goes to them. A new tick is taken in the cycle after the result is loaded.
// Reset (rst, synchronous) restores the registers and reloads all symbols.
module ema_welford_zscore_features_unit import ewz_pkg::*; #(
  parameter int NUM_SYMBOLS = NumSymbolsDef,
  parameter int IDX_W       = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // price
  input  logic [1:0]   s_tuser,   // symbol
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // fast_ema, slow_ema, mean_value, std_dev, z_score, pad
  output logic [2:0]   m_tuser    // out_symbol, zero_spread
);

  // Configuration registers. Writing the starting price also reloads every symbol.
  logic [15:0] fast_weight;
  logic [15:0] slow_weight;
  logic [30:0] start_level;
  logic        reload;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_weight <= AlphaFastReset;
      slow_weight <= AlphaSlowReset;
      start_level <= InitPriceReset;
    end else if (cfg_write) begin
      case (cfg_index)
        RegAlphaFast: fast_weight <= cfg_data[15:0];
        RegAlphaSlow: slow_weight <= cfg_data[15:0];
        RegInitPrice: start_level <= cfg_data;
        default:      fast_weight <= fast_weight;
      endcase
    end
  end

  assign reload = cfg_write && (cfg_index == RegInitPrice);

  // The symbol field selects a state slot modulo the number of symbols.
  function automatic logic [IDX_W-1:0] sym_slot(input logic [1:0] s);
    case (s)
      2'd0:    return IDX_W'(0);
      2'd1:    return IDX_W'(1 % NUM_SYMBOLS);
      2'd2:    return IDX_W'(2 % NUM_SYMBOLS);
      default: return IDX_W'(3 % NUM_SYMBOLS);
    endcase
  endfunction

  // Difference of price and an average, 33 bits signed.
  function automatic logic signed [32:0] ema_diff(input logic signed [31:0] p,
                                                 input logic signed [31:0] avg);
    return {p[31], p} - {avg[31], avg};
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  function automatic logic [48:0] mag49(input logic signed [48:0] x);
    return x[48] ? 49'(-x) : 49'(x);
  endfunction

  // New average from the serial product of |price - avg| and alpha, rounded
  // to the nearest step with ties toward plus infinity.
  function automatic logic signed [31:0] ema_post(input logic signed [31:0] avg,
                                                  input logic neg,
                                                  input logic [48:0] pmag);
    logic signed [49:0] sp;
    logic signed [49:0] rnd;
    sp  = neg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
    rnd = (sp + 50'sd32768) >>> FracBits;
    return avg + rnd[31:0];
  endfunction

  seq_state_t state;
  seq_state_t state_next;

  ser_cmd_t   cmd;
  ser_res_t   res;
  sym_state_t rd_data;
  sym_state_t wr_data;
  logic       rd_en;
  logic       wr_en;

  // Working registers of the current tick.
  logic [1:0]         sym_r;
  logic [IDX_W-1:0]   slot_r;
  logic signed [31:0] price_r;
  logic signed [31:0] fast_r;
  logic signed [31:0] slow_r;
  logic signed [47:0] mean_r;
  logic        [63:0] sum_r;
  logic        [31:0] n1_r;
  logic signed [48:0] delta_r;
  logic signed [48:0] delta2_r;
  logic        [63:0] var_r;
  logic        [30:0] sd_r;
  logic signed [31:0] z_r;
  logic               zero_r;

  logic signed [32:0] dfast;
  logic signed [32:0] dslow;
  logic signed [48:0] dmean;
  logic        [48:0] dmag;
  logic        [48:0] d2mag;
  logic        [31:0] n1_calc;
  logic        [63:0] dev_add;
  logic        [64:0] sum_add;
  logic        [48:0] qstep;
  logic        [48:0] zmag;
  logic signed [48:0] mean_rnd;
  logic signed [31:0] mean_out;
  logic               out_load;

  always_comb begin
    dfast = ema_diff(price_r, fast_r);
    dslow = ema_diff(price_r, slow_r);
    dmean = {price_r[31], price_r, 16'd0} - {mean_r[47], mean_r};
    dmag  = mag49(delta_r);
    d2mag = mag49(delta2_r);
    // The count stops at its maximum; at least two samples after the update.
    n1_calc = (rd_data.cnt == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd_data.cnt + 32'd1;
    if (n1_calc < 32'd2) begin
      n1_calc = 32'd2;
    end
    // Product bits from 2^(2F+64) upward mean the addend saturates.
    dev_add = (res.acc[48:47] != 2'b00) ? 64'hFFFF_FFFF_FFFF_FFFF
                                        : {res.acc[46:0], res.low[63:47]};
    sum_add  = {1'b0, sum_r} + {1'b0, dev_add};
    qstep    = res.low[48:0];
    zmag     = res.low[48:0];
    // Signed rounding shift: the mean rounds to the nearest step, ties toward plus infinity.
    mean_rnd = ($signed({mean_r[47], mean_r}) + 49'sd32768) >>> FracBits;
    if (mean_rnd > 49'sh0_0000_7FFF_FFFF) begin
      mean_out = 32'sh7FFF_FFFF;
    end else begin
      mean_out = mean_rnd[31:0];
    end
  end

  // Sequencer: next state and the commands to the serial unit and memory.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_MUL;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          rd_en      = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_FAST_GO;
      ST_FAST_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_MUL;
        cmd.a      = {31'd0, mag33(dfast)};
        cmd.b      = {48'd0, fast_weight};
        cmd.steps  = StepsEma;
        state_next = ST_FAST_WAIT;
      end
      ST_FAST_WAIT: if (res.done) state_next = ST_SLOW_GO;
      ST_SLOW_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_MUL;
        cmd.a      = {31'd0, mag33(dslow)};
        cmd.b      = {48'd0, slow_weight};
        cmd.steps  = StepsEma;
        state_next = ST_SLOW_WAIT;
      end
      ST_SLOW_WAIT: if (res.done) state_next = ST_MEAN_GO;
      ST_MEAN_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_DIV;
        cmd.a      = {32'd0, n1_r};
        cmd.b      = {mag49(dmean), 15'd0};
        cmd.steps  = StepsWide;
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: if (res.done) state_next = ST_DELTA2;
      ST_DELTA2: state_next = ST_DEV_GO;
      ST_DEV_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_MUL;
        cmd.a      = {15'd0, dmag};
        cmd.b      = {15'd0, d2mag};
        cmd.steps  = StepsWide;
        state_next = ST_DEV_WAIT;
      end
      ST_DEV_WAIT: if (res.done) state_next = ST_VAR_GO;
      ST_VAR_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_DIV;
        cmd.a      = {32'd0, n1_r - 32'd1};
        cmd.b      = sum_r;
        cmd.steps  = StepsVar;
        state_next = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: if (res.done) state_next = ST_SQRT_GO;
      ST_SQRT_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_SQRT;
        cmd.b      = var_r;
        cmd.steps  = StepsSqrt;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (res.done) begin
          state_next = (res.root == 32'd0) ? ST_DONE : ST_Z_GO;
        end
      end
      ST_Z_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_DIV;
        cmd.a      = {33'd0, sd_r};
        cmd.b      = {d2mag, 15'd0};
        cmd.steps  = StepsWide;
        state_next = ST_Z_WAIT;
      end
      ST_Z_WAIT: if (res.done) state_next = ST_DONE;
      ST_DONE: begin
        // Wait for the output register to be free, then commit the state.
        if (!m_tvalid || m_tready) begin
          wr_en      = 1'b1;
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, loaded as a tick is taken, at the state read and as each operation finishes.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          sym_r   <= s_tuser;
          slot_r  <= sym_slot(s_tuser);
          price_r <= s_tdata;
        end
      end
      ST_LOAD: begin
        fast_r <= rd_data.fast;
        slow_r <= rd_data.slow;
        mean_r <= rd_data.mean;
        sum_r  <= rd_data.sum;
        n1_r   <= n1_calc;
        z_r    <= 32'sd0;
        zero_r <= 1'b0;
      end
      ST_FAST_WAIT: begin
        if (res.done) begin
          fast_r <= ema_post(fast_r, dfast[32], {res.acc[32:0], res.low[63:48]});
        end
      end
      ST_SLOW_WAIT: begin
        if (res.done) begin
          slow_r <= ema_post(slow_r, dslow[32], {res.acc[32:0], res.low[63:48]});
        end
      end
      ST_MEAN_WAIT: begin
        if (res.done) begin
          delta_r <= dmean;
          mean_r  <= dmean[48] ? mean_r - qstep[47:0] : mean_r + qstep[47:0];
        end
      end
      ST_DELTA2: delta2_r <= dmean;
      ST_DEV_WAIT: begin
        if (res.done) begin
          sum_r <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
        end
      end
      ST_VAR_WAIT: begin
        if (res.done) begin
          var_r <= res.low;
        end
      end
      ST_SQRT_WAIT: begin
        if (res.done) begin
          sd_r   <= res.root[31] ? 31'h7FFF_FFFF : res.root[30:0];
          zero_r <= (res.root == 32'd0);
        end
      end
      ST_Z_WAIT: begin
        if (res.done) begin
          if (zmag >= 49'h0_0000_8000_0000) begin
            z_r <= delta2_r[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            z_r <= delta2_r[48] ? -$signed(zmag[31:0]) : $signed(zmag[31:0]);
          end
        end
      end
      default: begin
        price_r <= price_r;
      end
    endcase
  end

  always_comb begin
    wr_data.fast = fast_r;
    wr_data.slow = slow_r;
    wr_data.mean = mean_r;
    wr_data.sum  = sum_r;
    wr_data.cnt  = n1_r;
  end

  ewz_serial u_serial (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  ewz_state #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .IDX_W       (IDX_W)
  ) u_state (
    .clk         (clk),
    .rst         (rst),
    .clear       (reload),
    .rd_en       (rd_en),
    .rd_idx      (sym_slot(s_tuser)),
    .wr_en       (wr_en),
    .wr_idx      (slot_r),
    .wr_data     (wr_data),
    .start_level (start_level),
    .rd_data     (rd_data)
  );

  // Output register: the result waits here while the next tick is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, z_r, sd_r, mean_out, slow_r, fast_r};
      m_tuser <= {zero_r, sym_r};
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for ema_welford_zscore_features_unit: random and directed ticks,
// checked against a scoreboard class that predicts every feature. Needs ewz_pkg.
module tb;
  import ewz_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;  // index past the register list
  localparam int StallLimit = 20000;        // cycles without any transaction
  localparam int SettleCycles = 400;        // a little over one tick's latency

  // One result transaction, split into its fields.
  typedef struct {
    logic [1:0]         sym;
    logic signed [31:0] fast;
    logic signed [31:0] slow;
    logic signed [31:0] mean;
    logic [30:0]        sd;
    logic signed [31:0] z;
    logic               zero;
  } feat_t;

  // Keeps its own copy of the per-symbol state and the registers, predicts
  // the features of each accepted tick and checks results in order.
  class feature_scoreboard;
    longint          fast_avg[4];
    longint          slow_avg[4];
    longint          run_mean[4];
    longint unsigned sq_sum[4];
    longint unsigned n_seen[4];
    longint unsigned alpha_f, alpha_s, start_px;
    feat_t           pending[$];
    int              errors;

    function void reload();
      for (int i = 0; i < 4; i++) begin
        fast_avg[i] = longint'(start_px);
        slow_avg[i] = longint'(start_px);
        run_mean[i] = longint'(start_px) * 64'sd65536;
        sq_sum[i]   = 64'd0;
        n_seen[i]   = 64'd1;
      end
    endfunction

    function void power_on();
      alpha_f  = 64'(AlphaFastReset);
      alpha_s  = 64'(AlphaSlowReset);
      start_px = 64'(InitPriceReset);
      errors   = 0;
      reload();
    endfunction

    function void set_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        RegAlphaFast: alpha_f = 64'(val[15:0]);
        RegAlphaSlow: alpha_s = 64'(val[15:0]);
        RegInitPrice: begin
          start_px = 64'(val);
          reload();
        end
        default: ;
      endcase
    endfunction

    function longint ema(longint avg, longint px, longint unsigned alpha);
      longint prod;
      prod = (px - avg) * longint'(alpha);
      return avg + ((prod + 64'sd32768) >>> 16);
    endfunction

    function longint unsigned magn(longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Runs one tick through the symbol's averages and Welford statistics.
    function void note_tick(logic [1:0] sym, logic signed [31:0] price);
      feat_t           f;
      int              k;
      longint          px, pe, delta, delta2, q;
      longint unsigned n1, var_q, sd, zm;
      logic [127:0]    prod;
      logic [63:0]     add;
      logic [64:0]     total;
      k  = int'(sym);
      px = longint'(price);
      pe = px * 64'sd65536;
      fast_avg[k] = ema(fast_avg[k], px, alpha_f);
      slow_avg[k] = ema(slow_avg[k], px, alpha_s);
      n1 = (n_seen[k] < 64'hFFFF_FFFF) ? n_seen[k] + 1 : 64'hFFFF_FFFF;
      if (n1 < 2) n1 = 2;
      delta = pe - run_mean[k];
      q = longint'(magn(delta) / n1);
      run_mean[k] = run_mean[k] + ((delta < 0) ? -q : q);
      delta2 = pe - run_mean[k];
      prod = 128'(magn(delta)) * 128'(magn(delta2));
      add = (prod[127:96] != 0) ? '1 : prod[95:32];
      total = 65'(sq_sum[k]) + 65'(add);
      sq_sum[k] = total[64] ? '1 : total[63:0];
      n_seen[k] = n1;
      var_q = sq_sum[k] / (n1 - 1);
      sd = int_sqrt(var_q);
      if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
      f.sym  = sym;
      f.fast = fast_avg[k][31:0];
      f.slow = slow_avg[k][31:0];
      f.sd   = sd[30:0];
      f.zero = (sd == 0);
      if (f.zero) begin
        f.z = 32'sd0;
      end else begin
        zm = magn(delta2) / sd;
        if (zm > 64'h8000_0000) zm = 64'h8000_0000;
        f.z = 32'(clamp32((delta2 < 0) ? -longint'(zm) : longint'(zm)));
      end
      f.mean = 32'(clamp32((run_mean[k] + 64'sd32768) >>> 16));
      pending.push_back(f);
    endfunction

    function void field_cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [159:0] data, logic [2:0] user);
      feat_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %h %h", $time, user, data);
        return;
      end
      e = pending.pop_front();
      field_cmp("out_symbol", 32'(e.sym), 32'(user[1:0]));
      field_cmp("fast_ema", e.fast, data[31:0]);
      field_cmp("slow_ema", e.slow, data[63:32]);
      field_cmp("mean_value", e.mean, data[95:64]);
      field_cmp("std_dev", 32'(e.sd), 32'(data[126:96]));
      field_cmp("z_score", e.z, data[158:127]);
      field_cmp("zero_spread", 32'(e.zero), 32'(user[2]));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_write = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [30:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;   // price
  logic [1:0]   s_tuser = '0;   // symbol
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;        // fast_ema, slow_ema, mean_value, std_dev, z_score, pad
  logic [2:0]   m_tuser;        // out_symbol, zero_spread

  feature_scoreboard sb = new();
  bit calm = 1'b0;              // when set, neither side inserts idle cycles
  int quiet_cycles = 0;
  logic signed [31:0] center[4]; // drifting price level per symbol

  ema_welford_zscore_features_unit DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver holds m_tready low with a chance of 37 in 100 outside calm stretches.
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 37);
  end

  // Both sides are observed at the rising edge. A result always belongs to an
  // earlier tick, so the check goes first. The watchdog counts cycles in which
  // no transaction happens on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_tick(s_tuser, s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one tick and returns on the falling edge after it was taken.
  task automatic send_tick(logic [1:0] sym, logic [31:0] price);
    if (!calm && $urandom_range(0, 99) < 37) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = sym;
    s_tdata  = price;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Waits until every expected result has arrived and the unit has settled.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Mostly small moves around each symbol's level, so the statistics evolve
  // realistically; now and then a full-range value or an extreme.
  function automatic logic [31:0] pick_price(logic [1:0] sym);
    logic signed [31:0] p;
    case ($urandom_range(0, 9))
      6, 7: p = $urandom;
      8: p = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      9: p = center[sym];
      default: begin
        p = center[sym] + $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        center[sym] = p;
      end
    endcase
    return p;
  endfunction

  task automatic random_ticks(int count);
    logic [1:0] sym;
    for (int i = 0; i < count; i++) begin
      sym = 2'($urandom_range(0, 3));
      send_tick(sym, pick_price(sym));
    end
  endtask

  function automatic void recenter(logic [31:0] level);
    for (int i = 0; i < 4; i++) center[i] = level;
  endfunction

  initial begin
    sb.power_on();
    recenter(32'(InitPriceReset));
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Default weights. A tick at the starting price has no spread at all;
    // then the extremes of the price field on fresh symbols.
    send_tick(2'd0, 32'(InitPriceReset));
    send_tick(2'd0, 32'(InitPriceReset));
    send_tick(2'd0, 32'h0096_8000);
    send_tick(2'd1, 32'h7FFF_FFFF);
    send_tick(2'd1, 32'h8000_0000);
    send_tick(2'd1, 32'h7FFF_FFFF);
    send_tick(2'd2, 32'h0000_0000);
    send_tick(2'd2, 32'hFFFF_FFFF);
    send_tick(2'd3, 32'h0000_0001);
    send_tick(2'd3, 32'h0096_0000);
    random_ticks(120);
    calm = 1'b1;
    random_ticks(150);
    calm = 1'b0;

    // Full fast weight, no slow weight, top starting price: huge deviations
    // drive the squared sum and the outputs into saturation.
    drain();
    write_reg(RegAlphaFast, 31'hFFFF);
    write_reg(RegAlphaSlow, 31'h0);
    write_reg(RegInitPrice, 31'h7FFF_FFFF);
    write_reg(RegUnused, 31'($urandom));
    for (int i = 0; i < 4; i++) begin
      send_tick(2'(i), 32'h8000_0000);
      send_tick(2'(i), 32'h7FFF_FFFF);
    end
    send_tick(2'd0, 32'h8000_0000);
    recenter(32'h7FF0_0000);
    random_ticks(240);

    // No fast weight, full slow weight, zero starting price. Halfway the
    // sender holds off until the unit has nothing outstanding.
    drain();
    write_reg(RegAlphaFast, 31'h0);
    write_reg(RegAlphaSlow, 31'hFFFF);
    write_reg(RegInitPrice, 31'h0);
    recenter(32'h0);
    random_ticks(120);
    while (sb.pending.size() != 0) @(negedge clk);
    random_ticks(120);

    // Random settings for the rest.
    drain();
    write_reg(RegAlphaFast, 31'($urandom));
    write_reg(RegAlphaSlow, 31'($urandom));
    write_reg(RegInitPrice, 31'($urandom));
    recenter(32'(sb.start_px));
    random_ticks(310);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
